/* design/servo_pwm_generator_top_assert.svh */
// ----------------------------------------------------------------------------
// Servo PWM generator assertion macros
// Short forms for the concurrent checks on the generator's ports.
// ----------------------------------------------------------------------------
`ifndef SERVO_PWM_GENERATOR_TOP_ASSERT_SVH
`define SERVO_PWM_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, suspended while reset is asserted.
`define SPG_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, suspended while reset is asserted.
`define SPG_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Holds in the cycle after any cycle spent in reset.
`define SPG_CHECK_RESET(label, cons, msg) \
    label: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error(msg);

`endif

/* design/spg_pkg.sv */
// ----------------------------------------------------------------------------
// spg_pkg
// Shared types and constants of the servo PWM generator.
// ----------------------------------------------------------------------------
`default_nettype none

package spg_pkg;

    localparam int unsigned US_W      = 15;
    localparam int unsigned TOP_W     = 16;
    localparam int unsigned WIDTH_W   = 16;
    localparam int unsigned ANGLE_W   = 8;
    localparam int unsigned VALUE_W   = 16;
    localparam int unsigned NUM_W     = 23;  // 180 * 32767 fits in 23 bits
    localparam int unsigned ANGLE_MAX = 180;
    localparam int unsigned QDEPTH    = 2;

    // Division by 180 is a shift right by two followed by a multiply with the
    // rounded-up reciprocal of 45; exact for every dividend below 2^23.
    localparam int unsigned      RECIP_W      = 22;
    localparam int unsigned      DIV180_SHIFT = 27;
    localparam logic [RECIP_W-1:0] DIV180_RECIP = 22'd2982617;

    localparam logic [US_W-1:0]    RST_MIN_US     = 15'd544;
    localparam logic [US_W-1:0]    RST_MAX_US     = 15'd2400;
    localparam logic [US_W-1:0]    RST_DEFAULT_US = 15'd1500;
    localparam logic [TOP_W-1:0]   RST_PERIOD_TOP = 16'd40000;
    localparam logic [WIDTH_W-1:0] RST_WIDTH      = 16'd3000;
    localparam logic [ANGLE_W-1:0] RST_ANGLE      = 8'd92;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_ANGLE   = 2'd1,
        CMD_US      = 2'd2,
        CMD_RESTART = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_MIN_US     = 2'd0,
        REG_MAX_US     = 2'd1,
        REG_DEFAULT_US = 2'd2,
        REG_PERIOD_TOP = 2'd3
    } t_reg_idx;

    // Classified work for the back end.
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_ANGLE = 2'd1,
        OP_LOAD  = 2'd2
    } t_op_kind;

    typedef struct packed {
        t_op_kind         kind;
        logic [US_W-1:0]  data;   // clamped angle or final microseconds
    } t_op;

    typedef struct packed {
        logic [US_W-1:0]  min_us;
        logic [US_W-1:0]  max_us;
        logic [US_W-1:0]  default_us;
        logic [TOP_W-1:0] period_top;
    } t_cfg;

endpackage

`default_nettype wire

/* design/spg_front.sv */
// ----------------------------------------------------------------------------
// spg_front
// Accepts commands and turns them into back-end operations.
// ----------------------------------------------------------------------------
`default_nettype none

module spg_front
    import spg_pkg::*;
(
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_command,
    input  logic signed [VALUE_W-1:0] i_value,
    input  t_cfg                      i_cfg,
    input  logic                      i_q_full,
    output logic                      o_push,
    output t_op                       o_op
);

    logic                      w_below_min;
    logic                      w_above_max;
    logic [US_W-1:0]           w_us;
    logic [ANGLE_W-1:0]        w_angle;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    // Microsecond clamp; a value both below the minimum and above the maximum takes the minimum.
    assign w_below_min = i_value < $signed({1'b0, i_cfg.min_us});
    assign w_above_max = i_value > $signed({1'b0, i_cfg.max_us});
    assign w_us = w_below_min ? i_cfg.min_us :
                  w_above_max ? i_cfg.max_us : i_value[US_W-1:0];

    assign w_angle = i_value[VALUE_W-1] ? '0 :
                     (i_value > $signed(VALUE_W'(ANGLE_MAX))) ? ANGLE_W'(ANGLE_MAX) :
                     i_value[ANGLE_W-1:0];

    always_comb begin
        o_op.kind = OP_TICK;
        o_op.data = '0;
        case (t_cmd'(i_command))
            CMD_TICK: begin
                o_op.kind = OP_TICK;
            end
            CMD_ANGLE: begin
                o_op.kind = OP_ANGLE;
                o_op.data = US_W'(w_angle);
            end
            CMD_US: begin
                o_op.kind = OP_LOAD;
                o_op.data = w_us;
            end
            CMD_RESTART: begin
                o_op.kind = OP_LOAD;
                o_op.data = i_cfg.default_us;
            end
            default: begin
                o_op.kind = OP_TICK;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/spg_queue.sv */
// ----------------------------------------------------------------------------
// spg_queue
// Short operation queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module spg_queue
    import spg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    output logic o_valid,
    output t_op  o_op,
    input  logic i_pop
);

    localparam int unsigned PTR_W = $clog2(QDEPTH);
    localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

    t_op              r_slot [QDEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* design/spg_div.sv */
// ----------------------------------------------------------------------------
// spg_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module spg_div
    import spg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_dividend,
    input  logic [US_W-1:0]   i_divisor,
    output logic              o_done,
    output logic [NUM_W-1:0]  o_quotient
);

    localparam int unsigned CNT_W = $clog2(NUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [US_W-1:0]  r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [US_W-1:0]  r_den;
    logic [US_W:0]    w_trial;
    logic             w_fit;

    // The dividend shifts out of the top of r_quo while quotient bits enter below.
    assign w_trial    = {r_rem, r_quo[NUM_W-1]};
    assign w_fit      = (w_trial >= {1'b0, r_den});
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fit ? US_W'(w_trial - {1'b0, r_den}) : w_trial[US_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_fit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* design/spg_back.sv */
// ----------------------------------------------------------------------------
// spg_back
// Executes operations: PWM counter, pulse scaling, angle readback, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module spg_back
    import spg_pkg::*;
#(
    parameter int unsigned COUNTER_WIDTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_op_valid,
    input  t_op                i_op,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_pwm_level,
    output logic [US_W-1:0]    o_pulse_us,
    output logic [ANGLE_W-1:0] o_angle
);

    localparam int unsigned CMP_W  = (COUNTER_WIDTH > WIDTH_W) ? COUNTER_WIDTH : WIDTH_W;
    localparam int unsigned PROD_W = NUM_W - 2 + RECIP_W;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MUL   = 7'b0000010,
        S_SCALE = 7'b0000100,
        S_READ  = 7'b0001000,
        S_RMUL  = 7'b0010000,
        S_DIV_R = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state                   r_state;
    t_state                   n_state;
    logic [COUNTER_WIDTH-1:0] r_count;
    logic [WIDTH_W-1:0]       r_active;
    logic [WIDTH_W-1:0]       r_pending;
    logic [ANGLE_W-1:0]       r_readback;
    logic [US_W-1:0]          r_us;
    logic [ANGLE_W-1:0]       r_ang;
    logic [NUM_W-1:0]         r_num;
    logic [PROD_W-1:0]        r_prod;
    logic                     r_out_valid;
    logic                     r_out_level;
    logic [US_W-1:0]          r_out_us;
    logic [ANGLE_W-1:0]       r_out_ang;

    logic                     w_out_free;
    logic                     w_tick;
    logic                     w_wrap;
    logic [COUNTER_WIDTH-1:0] w_count_nx;
    logic [WIDTH_W-1:0]       w_active_nx;
    logic [US_W-1:0]          w_span;
    logic [US_W:0]            w_sum;
    logic                     w_div_start;
    logic                     w_div_done;
    logic [NUM_W-1:0]         w_div_quo;
    logic                     w_out_write;

    assign w_out_free = !r_out_valid || i_ready;
    assign w_tick     = (r_state == S_IDLE) && i_op_valid && (i_op.kind == OP_TICK)
                        && w_out_free;
    assign o_pop      = w_tick || ((r_state == S_IDLE) && i_op_valid
                        && (i_op.kind != OP_TICK));

    // Fast PWM: wrap past the top value and load the pending width at the wrap.
    assign w_wrap      = CMP_W'(r_count) >= CMP_W'(i_cfg.period_top);
    assign w_count_nx  = w_wrap ? '0 : r_count + 1'b1;
    assign w_active_nx = w_wrap ? r_pending : r_active;

    assign w_span = (i_cfg.max_us >= i_cfg.min_us) ? i_cfg.max_us - i_cfg.min_us : '0;
    // The scaled angle term is the product bits above the reciprocal's shift.
    assign w_sum  = {1'b0, i_cfg.min_us} + {1'b0, r_prod[DIV180_SHIFT +: US_W]};

    assign w_div_start = (r_state == S_RMUL);
    assign w_out_write = w_tick || ((r_state == S_OUT) && w_out_free);

    spg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_num),
        .i_divisor  (w_span),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_op_valid && (i_op.kind == OP_ANGLE)) begin
                    n_state = S_MUL;
                end else if (i_op_valid && (i_op.kind == OP_LOAD)) begin
                    n_state = S_READ;
                end
            end
            S_MUL:   n_state = S_SCALE;
            S_SCALE: n_state = S_READ;
            S_READ: begin
                if ((r_us <= i_cfg.min_us) || (i_cfg.max_us <= i_cfg.min_us)) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_RMUL;
                end
            end
            S_RMUL:  n_state = S_DIV_R;
            S_DIV_R: n_state = w_div_done ? S_OUT : S_DIV_R;
            S_OUT:   n_state = w_out_free ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    // Working values of a set operation.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_op_valid && (i_op.kind == OP_ANGLE)) begin
                    r_num <= NUM_W'(w_span) * NUM_W'(i_op.data[ANGLE_W-1:0]);
                end
                r_us <= i_op.data;
            end
            S_MUL: begin
                r_prod <= PROD_W'(r_num[NUM_W-1:2]) * PROD_W'(DIV180_RECIP);
            end
            S_SCALE: begin
                r_us <= (w_sum > {1'b0, i_cfg.max_us}) ? i_cfg.max_us : w_sum[US_W-1:0];
            end
            S_READ: begin
                if (r_us <= i_cfg.min_us) begin
                    r_ang <= '0;
                end else if (i_cfg.max_us <= i_cfg.min_us) begin
                    r_ang <= ANGLE_W'(ANGLE_MAX);
                end
                r_num <= NUM_W'(r_us - i_cfg.min_us) * NUM_W'(ANGLE_MAX);
            end
            S_DIV_R: begin
                if (w_div_done) begin
                    r_ang <= (w_div_quo > NUM_W'(ANGLE_MAX)) ? ANGLE_W'(ANGLE_MAX)
                                                             : w_div_quo[ANGLE_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_active    <= RST_WIDTH;
            r_pending   <= RST_WIDTH;
            r_readback  <= RST_ANGLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_tick) begin
                r_count  <= w_count_nx;
                r_active <= w_active_nx;
            end
            if ((r_state == S_OUT) && w_out_free) begin
                r_pending  <= {r_us, 1'b0};
                r_readback <= r_ang;
            end
            if (w_out_write) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register; a set operation leaves the counter alone.
    always_ff @(posedge i_clk) begin
        if (w_tick) begin
            r_out_level <= CMP_W'(w_count_nx) < CMP_W'(w_active_nx);
            r_out_us    <= r_pending[WIDTH_W-1:1];
            r_out_ang   <= r_readback;
        end else if (w_out_write) begin
            r_out_level <= CMP_W'(r_count) < CMP_W'(r_active);
            r_out_us    <= r_us;
            r_out_ang   <= r_ang;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pwm_level = r_out_level;
    assign o_pulse_us  = r_out_us;
    assign o_angle     = r_out_ang;

endmodule

`default_nettype wire

/* design/servo_pwm_generator_top.sv */
// ----------------------------------------------------------------------------
// servo_pwm_generator_top
// One-channel RC servo pulse generator with a command stream and APB registers.
// ----------------------------------------------------------------------------
// Usage:
// Commands enter on i_valid/o_ready: a 2 MHz tick, set angle, set microseconds
// or restart. Every transfer in produces exactly one result transfer on
// o_valid/i_ready carrying the output level, the commanded pulse in
// microseconds and the readback angle.
// A tick result passes through the queue and the result register, and ticks
// are taken one per cycle while the receiver keeps up and no set command is
// in progress. A set microseconds or restart command passes the readback step
// and goes straight to the result when the readback is 0 or 180 outright,
// otherwise through the serial divider of the angle readback. A set angle
// command first adds the reciprocal scaling of the angle, multiply then scale.
// A two-entry queue sits between command decode and execution, so commands
// are still accepted while the back end is busy or a result waits for the
// receiver; o_ready drops only when the queue is full.
// Reset restores the register defaults, clears the counter and loads a
// 1500 us pulse with a readback angle of 92. Registers must be written over APB
// only while no command is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_pwm_generator_top
    import spg_pkg::*;
#(
    parameter int unsigned COUNTER_WIDTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_psel,
    input  logic                      i_penable,
    input  logic                      i_pwrite,
    input  logic [3:0]                i_paddr,
    input  logic [31:0]               i_pwdata,
    output logic [31:0]               o_prdata,
    output logic                      o_pready,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_command,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_pwm_level,
    output logic [US_W-1:0]           o_pulse_us,
    output logic [ANGLE_W-1:0]        o_angle
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;
    logic     w_push;
    t_op      w_push_op;
    logic     w_q_full;
    logic     w_q_valid;
    t_op      w_q_op;
    logic     w_pop;

    assign o_pready = 1'b1;
    assign w_idx    = t_reg_idx'(i_paddr[3:2]);
    assign w_wr     = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_us     <= RST_MIN_US;
            r_cfg.max_us     <= RST_MAX_US;
            r_cfg.default_us <= RST_DEFAULT_US;
            r_cfg.period_top <= RST_PERIOD_TOP;
        end else if (w_wr) begin
            case (w_idx)
                REG_MIN_US:     r_cfg.min_us     <= i_pwdata[US_W-1:0];
                REG_MAX_US:     r_cfg.max_us     <= i_pwdata[US_W-1:0];
                REG_DEFAULT_US: r_cfg.default_us <= i_pwdata[US_W-1:0];
                REG_PERIOD_TOP: r_cfg.period_top <= i_pwdata[TOP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_MIN_US:     o_prdata = 32'(r_cfg.min_us);
            REG_MAX_US:     o_prdata = 32'(r_cfg.max_us);
            REG_DEFAULT_US: o_prdata = 32'(r_cfg.default_us);
            REG_PERIOD_TOP: o_prdata = 32'(r_cfg.period_top);
            default:        o_prdata = '0;
        endcase
    end

    spg_front u_front (
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_command (i_command),
        .i_value   (i_value),
        .i_cfg     (r_cfg),
        .i_q_full  (w_q_full),
        .o_push    (w_push),
        .o_op      (w_push_op)
    );

    spg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_push_op),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_op    (w_q_op),
        .i_pop   (w_pop)
    );

    spg_back #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_op_valid  (w_q_valid),
        .i_op        (w_q_op),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pwm_level (o_pwm_level),
        .o_pulse_us  (o_pulse_us),
        .o_angle     (o_angle)
    );

endmodule

`default_nettype wire

/* design/spg_checker.sv */
// ----------------------------------------------------------------------------
// spg_checker
// Port-level checks of the servo PWM generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "servo_pwm_generator_top_assert.svh"

module spg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_psel,
    input logic        i_penable,
    input logic        i_pwrite,
    input logic [3:0]  i_paddr,
    input logic [31:0] i_pwdata,
    input logic [31:0] o_prdata,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_pwm_level,
    input logic [14:0] o_pulse_us,
    input logic [7:0]  o_angle
);

    // A stalled result keeps its contents until the transfer completes.
    `SPG_CHECK_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_pwm_level) && $stable(o_pulse_us) && $stable(o_angle), "stalled result changed")

    // The readback is saturated at 180 degrees.
    `SPG_CHECK_NOW(a_angle_range, o_valid, o_angle <= 8'd180, "readback angle above 180")

    // No result may be left over from before reset.
    `SPG_CHECK_RESET(a_reset_empty, !o_valid, "result valid right after reset")

    // A write to the minimum register reads back masked to 15 bits.
    `SPG_CHECK_NOW(a_min_readback, $past(i_rst_n) && $past(i_psel && i_penable && i_pwrite && (i_paddr[3:2] == 2'd0)) && (i_paddr[3:2] == 2'd0) && !(i_psel && i_penable && i_pwrite), o_prdata == {17'd0, $past(i_pwdata[14:0])}, "minimum register readback mismatch")

endmodule

bind servo_pwm_generator_top spg_checker u_spg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_psel      (i_psel),
    .i_penable   (i_penable),
    .i_pwrite    (i_pwrite),
    .i_paddr     (i_paddr),
    .i_pwdata    (i_pwdata),
    .o_prdata    (o_prdata),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_pwm_level (o_pwm_level),
    .o_pulse_us  (o_pulse_us),
    .o_angle     (o_angle)
);

`default_nettype wire

/* bench/servo_pwm_generator_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// servo_pwm_generator_top_tb
// Drives set, restart and tick commands into the servo pulse generator and
// compares every result with a cycle-free model of the counter, the pending
// and active widths and the angle readback, across several register settings.
// ----------------------------------------------------------------------------

module servo_pwm_generator_top_tb;

    import spg_pkg::*;

    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned TAIL_CYCLES = 80;

    typedef struct packed {
        logic               level;
        logic [US_W-1:0]    pulse_us;
        logic [ANGLE_W-1:0] angle;
    } t_servo_out;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_psel;
    logic                      i_penable;
    logic                      i_pwrite;
    logic [3:0]                i_paddr;
    logic [31:0]               i_pwdata;
    logic [31:0]               o_prdata;
    logic                      o_pready;
    logic                      i_valid;
    logic                      o_ready;
    t_cmd                      i_command;
    logic signed [VALUE_W-1:0] i_value;
    logic                      o_valid;
    logic                      i_ready;
    logic                      o_pwm_level;
    logic [US_W-1:0]           o_pulse_us;
    logic [ANGLE_W-1:0]        o_angle;

    // Register mirror.
    logic [US_W-1:0]    cfg_min;
    logic [US_W-1:0]    cfg_max;
    logic [US_W-1:0]    cfg_default;
    logic [TOP_W-1:0]   cfg_top;

    // Channel state as the model sees it.
    logic [15:0]        m_count;
    logic [WIDTH_W-1:0] m_active;
    logic [WIDTH_W-1:0] m_pending;
    logic [ANGLE_W-1:0] m_angle;

    t_servo_out predicted_outputs[$];
    t_servo_out want;

    int  errors;
    int  commands_sent;
    int  set_commands;
    int  results_seen;
    int  settings_used;
    int  ready_hold;
    int  quiet_cycles;
    bit  no_idle;

    servo_pwm_generator_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_psel      (i_psel),
        .i_penable   (i_penable),
        .i_pwrite    (i_pwrite),
        .i_paddr     (i_paddr),
        .i_pwdata    (i_pwdata),
        .o_prdata    (o_prdata),
        .o_pready    (o_pready),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_command   (i_command),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pwm_level (o_pwm_level),
        .o_pulse_us  (o_pulse_us),
        .o_angle     (o_angle)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int draw_gap();
        if (no_idle) begin
            return 0;
        end
        return $urandom_range(0, 4);
    endfunction

    // Stores a pulse in counts and derives the readback angle from it.
    function automatic void load_pulse(int unsigned us);
        int unsigned a;
        m_pending = (us * 2) & 16'hFFFF;
        if (us <= cfg_min) begin
            a = 0;
        end else if (cfg_max <= cfg_min) begin
            a = ANGLE_MAX;
        end else begin
            a = (ANGLE_MAX * (us - cfg_min)) / (cfg_max - cfg_min);
            if (a > ANGLE_MAX) begin
                a = ANGLE_MAX;
            end
        end
        m_angle = a[ANGLE_W-1:0];
    endfunction

    function automatic void clamp_and_load(int v);
        if (v < int'(cfg_min)) begin
            load_pulse(cfg_min);
        end else if (v > int'(cfg_max)) begin
            load_pulse(cfg_max);
        end else begin
            load_pulse(v);
        end
    endfunction

    function automatic t_servo_out next_servo_output(t_cmd cmd, logic signed [15:0] val);
        int          v;
        int          deg;
        int unsigned span;
        t_servo_out  r;
        v = val;
        case (cmd)
            CMD_TICK: begin
                if (m_count >= cfg_top) begin
                    m_count  = '0;
                    m_active = m_pending;
                end else begin
                    m_count = m_count + 16'd1;
                end
            end
            CMD_ANGLE: begin
                deg  = v < 0 ? 0 : (v > int'(ANGLE_MAX) ? int'(ANGLE_MAX) : v);
                span = cfg_max >= cfg_min ? cfg_max - cfg_min : 0;
                clamp_and_load(int'(cfg_min + (span * deg) / ANGLE_MAX));
            end
            CMD_US: begin
                clamp_and_load(v);
            end
            default: begin
                load_pulse(cfg_default);
            end
        endcase
        r.level    = m_count < m_active;
        r.pulse_us = m_pending[WIDTH_W-1:1];
        r.angle    = m_angle;
        return r;
    endfunction

    // One command transfer; the prediction is queued at the accepting edge.
    task automatic send_cmd(t_cmd cmd, logic signed [15:0] val);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_value   <= val;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predicted_outputs.push_back(next_servo_output(cmd, val));
        commands_sent++;
        if (cmd != CMD_TICK) begin
            set_commands++;
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (predicted_outputs.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes one register, then reads it back.
    task automatic reg_write(t_reg_idx idx, logic [31:0] data);
        logic [31:0] stored;
        case (idx)
            REG_MIN_US: begin
                cfg_min = data[US_W-1:0];
                stored  = 32'(cfg_min);
            end
            REG_MAX_US: begin
                cfg_max = data[US_W-1:0];
                stored  = 32'(cfg_max);
            end
            REG_DEFAULT_US: begin
                cfg_default = data[US_W-1:0];
                stored      = 32'(cfg_default);
            end
            default: begin
                cfg_top = data[TOP_W-1:0];
                stored  = 32'(cfg_top);
            end
        endcase
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {idx, 2'b00};
        i_pwdata  <= data;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        if (o_prdata !== stored) begin
            $display("%0t: register %s readback: expected %0d, actual %0d",
                     $time, idx.name(), stored, o_prdata);
            errors++;
        end
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
    endtask

    task automatic apply_settings(int unsigned lo_us, int unsigned hi_us,
                                  int unsigned def_us, int unsigned top);
        drain_results();
        reg_write(REG_MIN_US, lo_us);
        reg_write(REG_MAX_US, hi_us);
        reg_write(REG_DEFAULT_US, def_us);
        reg_write(REG_PERIOD_TOP, top);
        settings_used++;
    endtask

    task automatic test_reset_defaults();
        send_cmd(CMD_TICK, 16'sd0);
        send_cmd(CMD_RESTART, 16'sd0);
        send_cmd(CMD_ANGLE, 16'sd0);
        send_cmd(CMD_ANGLE, 16'sd180);
        send_cmd(CMD_ANGLE, -16'sd32768);
        send_cmd(CMD_ANGLE, 16'sd32767);
        send_cmd(CMD_ANGLE, 16'sd90);
        send_cmd(CMD_US, -16'sd32768);
        send_cmd(CMD_US, 16'sd32767);
        send_cmd(CMD_US, 16'sd0);
        send_cmd(CMD_US, 16'sd1500);
        send_cmd(CMD_TICK, 16'sd0);
    endtask

    // With the top at zero the counter never leaves zero and reloads each tick.
    task automatic test_period_top_zero();
        apply_settings(1, 40, 3, 0);
        send_cmd(CMD_US, 16'sd5);
        send_cmd(CMD_TICK, 16'sd0);
        send_cmd(CMD_TICK, 16'sd0);
        send_cmd(CMD_RESTART, -16'sd1);
        send_cmd(CMD_TICK, 16'sd0);
    endtask

    task automatic test_max_below_min();
        apply_settings(30, 10, 3, 6);
        send_cmd(CMD_ANGLE, 16'sd90);
        send_cmd(CMD_US, 16'sd5);
        send_cmd(CMD_US, 16'sd20);
        send_cmd(CMD_US, 16'sd40);
        send_cmd(CMD_RESTART, 16'sd0);
        send_cmd(CMD_TICK, 16'sd0);
    endtask

    task automatic test_random_traffic(int count);
        int          pick;
        int          edge_us;
        logic [15:0] val;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 59) == 0) begin
                drain_results();
            end
            pick = $urandom_range(0, 99);
            val  = $urandom;
            if (pick < 70) begin
                send_cmd(CMD_TICK, val);
            end else if (pick < 81) begin
                case ($urandom_range(0, 4))
                    0, 1, 2: val = $urandom_range(0, ANGLE_MAX);
                    3:       val = $urandom_range(ANGLE_MAX - 4, ANGLE_MAX + 4);
                    default: ;
                endcase
                send_cmd(CMD_ANGLE, val);
            end else if (pick < 93) begin
                case ($urandom_range(0, 3))
                    0, 1: begin
                        if (cfg_min <= cfg_max) begin
                            val = $urandom_range(cfg_min, cfg_max);
                        end else begin
                            val = $urandom_range(0, 32767);
                        end
                    end
                    2: begin
                        edge_us = ($urandom_range(0, 1) ? int'(cfg_min) : int'(cfg_max))
                                  + int'($urandom_range(0, 4)) - 2;
                        val = edge_us[15:0];
                    end
                    default: ;
                endcase
                send_cmd(CMD_US, val);
            end else begin
                send_cmd(CMD_RESTART, val);
            end
        end
        no_idle = 1'b0;
    endtask

    // Result checking and the receiver's ready pattern.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            ready_hold = 0;
        end else begin
            if (o_valid && i_ready) begin
                results_seen++;
                if (predicted_outputs.size() == 0) begin
                    $display("%0t: unexpected result: level %0d pulse_us %0d angle %0d",
                             $time, o_pwm_level, o_pulse_us, o_angle);
                    errors++;
                end else begin
                    want = predicted_outputs.pop_front();
                    if (o_pwm_level !== want.level) begin
                        $display("%0t: pwm_level: expected %0d, actual %0d",
                                 $time, want.level, o_pwm_level);
                        errors++;
                    end
                    if (o_pulse_us !== want.pulse_us) begin
                        $display("%0t: pulse_us: expected %0d, actual %0d",
                                 $time, want.pulse_us, o_pulse_us);
                        errors++;
                    end
                    if (o_angle !== want.angle) begin
                        $display("%0t: angle: expected %0d, actual %0d",
                                 $time, want.angle, o_angle);
                        errors++;
                    end
                end
                ready_hold = draw_gap();
            end else if (!i_ready && ready_hold > 0) begin
                ready_hold--;
            end
            i_ready <= (ready_hold == 0);
        end
    end

    // Ends the run if no transfer of any kind happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || i_psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n   <= 1'b0;
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
        i_paddr   <= '0;
        i_pwdata  <= '0;
        i_valid   <= 1'b0;
        i_command <= CMD_TICK;
        i_value   <= '0;
        quiet_cycles <= 0;
        errors        = 0;
        commands_sent = 0;
        set_commands  = 0;
        results_seen  = 0;
        settings_used = 1;
        no_idle       = 1'b0;
        cfg_min     = RST_MIN_US;
        cfg_max     = RST_MAX_US;
        cfg_default = RST_DEFAULT_US;
        cfg_top     = RST_PERIOD_TOP;
        m_count     = '0;
        m_active    = RST_WIDTH;
        m_pending   = RST_WIDTH;
        m_angle     = RST_ANGLE;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_period_top_zero();
        test_max_below_min();

        apply_settings(2, 20, 10, 30);
        test_random_traffic(150);
        apply_settings(0, 32767, 0, 1);
        test_random_traffic(150);
        apply_settings(20000, 20000, 20000, 65535);
        test_random_traffic(150);
        apply_settings(5, 3, 7, 12);
        test_random_traffic(150);
        apply_settings(0, 15, 32767, 40);
        test_random_traffic(150);
        apply_settings(1, 50, 25, 0);
        test_random_traffic(150);
        for (int k = 0; k < 2; k++) begin
            apply_settings($urandom_range(0, 20), $urandom_range(0, 60),
                           $urandom_range(0, 60), $urandom_range(0, 80));
            test_random_traffic(150);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (predicted_outputs.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, predicted_outputs.size());
            errors++;
        end
        $display("Sent %0d commands (%0d set or restart) and checked %0d results",
                 commands_sent, set_commands, results_seen);
        $display("over %0d register settings; %0d mismatches", settings_used, errors);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
